@@ hw/rtl/mmr_pkg.sv @@
// Shared types, codes and the per-wheel ramp function of the mecanum mixer.
`timescale 1ns / 1ps

package mmr_pkg;

    localparam int WHEELS      = 4;
    localparam int DEMAND_W    = 11;
    localparam int MIX_W       = 13;
    localparam int DUTY_W      = 8;
    localparam int STEP_W      = 6;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int WHEEL_RES_W = DUTY_W + 2;

    localparam logic [DUTY_W-1:0] SPEED_LIMIT_RST = 8'd255;
    localparam logic [STEP_W-1:0] RAMP_STEP_RST   = 6'd5;

    typedef enum logic {
        OP_DRIVE = 1'b0,
        OP_STOP  = 1'b1
    } opcode_t;

    typedef enum logic {
        REG_SPEED_LIMIT = 1'b0,
        REG_RAMP_STEP   = 1'b1
    } reg_idx_t;

    // Packed so that duty sits in the lowest bits, then forward, then flipped.
    typedef struct packed {
        logic              flipped;
        logic              forward;
        logic [DUTY_W-1:0] duty;
    } wheel_res_t;

    // Clamp the mixed demand, handle a direction change, then ramp and limit.
    function automatic wheel_res_t wheel_update(
        input logic signed [MIX_W-1:0] mix,
        input logic [DUTY_W-1:0]       speed,
        input logic                    dir,
        input logic [DUTY_W-1:0]       limit,
        input logic [STEP_W-1:0]       step
    );
        logic signed [8:0] tgt;
        logic              new_dir;
        logic [7:0]        mag;
        logic [7:0]        spd0;
        logic signed [9:0] nxt;
        wheel_res_t        res;
        if (mix > 13'sd255) begin
            tgt = 9'sd255;
        end else if (mix < -13'sd255) begin
            tgt = -9'sd255;
        end else begin
            tgt = mix[8:0];
        end
        new_dir     = ~tgt[8];
        mag         = tgt[8] ? 8'(-tgt) : 8'(tgt);
        res.flipped = (new_dir != dir);
        res.forward = new_dir;
        spd0        = res.flipped ? '0 : speed;
        if (mag > spd0) begin
            nxt = $signed({2'b00, spd0}) + $signed({4'b0000, step});
        end else begin
            nxt = $signed({2'b00, spd0}) - $signed({2'b00, step, 2'b00});
        end
        if (nxt < 10'sd0) begin
            res.duty = '0;
        end else if (nxt > $signed({2'b00, limit})) begin
            res.duty = limit;
        end else begin
            res.duty = nxt[7:0];
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/mecanum_mixer_with_ramp_unit.sv @@
// Top level of the mecanum wheel mixer with per-wheel slew-rate limit.
`timescale 1ns / 1ps

// Mecanum mixer with ramp. Each input transaction is a drive command
// (s_tuser = 0) carrying throttle, strafe and rotation, or a stop
// (s_tuser = 1). Every input transaction yields exactly one output
// transaction holding duty, direction and a flip flag for all four wheels.
// A drive command mixes the demands into a target per wheel (front right
// t+s+r, front left t+s-r, rear right t-s+r, rear left t-s-r), clamps it to
// -255..255, zeroes the wheel and raises its flag on a sign change, then
// ramps the speed up by ramp_step or down by four times ramp_step and
// clamps it to 0..speed_limit. A stop zeroes all speeds and keeps the
// directions. Timing: two register stages, the input register and then the
// output register that drives m_tvalid and m_tdata; one transaction is taken
// every cycle while the output is not stalled, since the wheel state is read
// and written within the second stage. Speeds reset to zero, directions to
// forward, speed_limit to 255 and ramp_step to 5. Write the registers over
// the APB port only while the
// block is idle: speed_limit at address 0, ramp_step at address 4.
module mecanum_mixer_with_ramp_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mmr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mmr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mmr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    // Command stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: throttle [10:0], strafe [21:11], rotation [32:22], zero pad [39:33]
    input  logic [mmr_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: opcode [0]
    input  logic                             s_tuser,
    // Wheel state stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: fr_duty [7:0], fr_forward [8], fr_flipped [9],
    //          fl_duty [17:10], fl_forward [18], fl_flipped [19],
    //          rr_duty [27:20], rr_forward [28], rr_flipped [29],
    //          rl_duty [37:30], rl_forward [38], rl_flipped [39]
    output logic [mmr_pkg::M_TDATA_W-1:0]    m_tdata
);

    import mmr_pkg::*;

    // Configuration registers
    logic [DUTY_W-1:0] speed_limit_reg;
    logic [STEP_W-1:0] ramp_step_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    // Input stage
    logic                       in_vld_reg, in_vld_next;
    opcode_t                    in_op_reg;
    logic signed [DEMAND_W-1:0] thr_reg, str_reg, rot_reg;

    // Wheel state
    logic [DUTY_W-1:0] speed_reg [WHEELS];
    logic              dir_reg   [WHEELS];

    // Output stage
    logic                 out_vld_reg, out_vld_next;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic                    out_adv;
    logic                    stage2_fire;
    logic                    s_fire;
    logic signed [MIX_W-1:0] mix     [WHEELS];
    wheel_res_t              wres    [WHEELS];
    logic [M_TDATA_W-1:0]    out_data_next;

    // APB: write lands in the access cycle; pready is tied high
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_comb begin
        case (cfg_idx)
            REG_SPEED_LIMIT: prdata = APB_DATA_W'(speed_limit_reg);
            REG_RAMP_STEP:   prdata = APB_DATA_W'(ramp_step_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_limit_reg <= SPEED_LIMIT_RST;
            ramp_step_reg   <= RAMP_STEP_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SPEED_LIMIT: speed_limit_reg <= pwdata[DUTY_W-1:0];
                REG_RAMP_STEP:   ramp_step_reg   <= pwdata[STEP_W-1:0];
                default:         ;
            endcase
        end
    end

    // Handshake: the output register frees when empty or being drained,
    // and the input register frees when its transaction moves on
    assign out_adv     = !out_vld_reg || m_tready;
    assign s_tready    = !in_vld_reg || out_adv;
    assign s_fire      = s_tvalid && s_tready;
    assign stage2_fire = in_vld_reg && out_adv;

    assign in_vld_next  = s_tready ? s_tvalid : in_vld_reg;
    assign out_vld_next = out_adv ? in_vld_reg : out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Capture the command payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg <= opcode_t'(s_tuser);
            thr_reg   <= s_tdata[10:0];
            str_reg   <= s_tdata[21:11];
            rot_reg   <= s_tdata[32:22];
        end
    end

    // Mix the demands; sign pattern per wheel fr, fl, rr, rl
    assign mix[0] = MIX_W'(thr_reg) + MIX_W'(str_reg) + MIX_W'(rot_reg);
    assign mix[1] = MIX_W'(thr_reg) + MIX_W'(str_reg) - MIX_W'(rot_reg);
    assign mix[2] = MIX_W'(thr_reg) - MIX_W'(str_reg) + MIX_W'(rot_reg);
    assign mix[3] = MIX_W'(thr_reg) - MIX_W'(str_reg) - MIX_W'(rot_reg);

    // Per wheel: ramp on drive; on stop zero the speed, hold direction, no flag
    always_comb begin
        for (int k = 0; k < WHEELS; k++) begin
            if (in_op_reg == OP_STOP) begin
                wres[k].duty    = '0;
                wres[k].forward = dir_reg[k];
                wres[k].flipped = 1'b0;
            end else begin
                wres[k] = wheel_update(mix[k], speed_reg[k], dir_reg[k],
                                       speed_limit_reg, ramp_step_reg);
            end
        end
    end

    assign out_data_next = {wres[3], wres[2], wres[1], wres[0]};

    // Advance the wheel state together with the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < WHEELS; k++) begin
                speed_reg[k] <= '0;
                dir_reg[k]   <= 1'b1;
            end
        end else if (stage2_fire) begin
            for (int k = 0; k < WHEELS; k++) begin
                speed_reg[k] <= wres[k].duty;
                dir_reg[k]   <= wres[k].forward;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage2_fire) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ tb/tb_mecanum_mixer_with_ramp_unit.sv @@
// Self-checking testbench for the mecanum mixer with per-wheel ramp.
`timescale 1ns / 1ps

module tb_mecanum_mixer_with_ramp_unit;
    import mmr_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 9;
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int TAIL_CYCLES    = 6;     // margin for the pipeline to empty after the last result
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction on either stream
    localparam int REPORT_LIMIT   = 10;
    localparam int TARGET_BOUND   = 255;
    localparam int DECEL_MULT     = 4;
    localparam int DEMAND_MIN     = -1024;
    localparam int DEMAND_MAX     = 1023;

    // Tracks wheel speeds and directions alongside the block and holds the
    // wheel states it should report, oldest first.
    class wheel_ramp_tracker;
        typedef wheel_res_t [WHEELS-1:0] wheel_set_t;

        logic [DUTY_W-1:0] speed [WHEELS];
        logic              forward [WHEELS];
        logic [DUTY_W-1:0] speed_limit;
        logic [STEP_W-1:0] ramp_step;
        wheel_set_t        pending_states [$];
        int                mismatches;
        int                stray_results;
        int                reported;
        int                result_index;

        function new();
            speed_limit   = SPEED_LIMIT_RST;
            ramp_step     = RAMP_STEP_RST;
            mismatches    = 0;
            stray_results = 0;
            reported      = 0;
            result_index  = 0;
            for (int k = 0; k < WHEELS; k++) begin
                speed[k]   = '0;
                forward[k] = 1'b1;
            end
        endfunction

        function void set_register(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_SPEED_LIMIT: speed_limit = value[DUTY_W-1:0];
                REG_RAMP_STEP:   ramp_step   = value[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_command(opcode_t op, logic signed [DEMAND_W-1:0] thr,
                                   logic signed [DEMAND_W-1:0] str,
                                   logic signed [DEMAND_W-1:0] rot);
            int         mix [WHEELS];
            int         target;
            int         mag;
            int         next_speed;
            logic       dir_now;
            wheel_set_t states;
            // Mix order: front right, front left, rear right, rear left.
            mix[0] = int'(thr) + int'(str) + int'(rot);
            mix[1] = int'(thr) + int'(str) - int'(rot);
            mix[2] = int'(thr) - int'(str) + int'(rot);
            mix[3] = int'(thr) - int'(str) - int'(rot);
            for (int k = 0; k < WHEELS; k++) begin
                if (op == OP_STOP) begin
                    speed[k]          = '0;
                    states[k].flipped = 1'b0;
                end else begin
                    target = mix[k];
                    if (target > TARGET_BOUND) target = TARGET_BOUND;
                    if (target < -TARGET_BOUND) target = -TARGET_BOUND;
                    // Zero counts as forward.
                    dir_now           = (target >= 0);
                    states[k].flipped = (dir_now != forward[k]);
                    if (states[k].flipped) begin
                        speed[k]   = '0;
                        forward[k] = dir_now;
                    end
                    mag = (target < 0) ? -target : target;
                    if (mag > int'(speed[k])) begin
                        next_speed = int'(speed[k]) + int'(ramp_step);
                    end else begin
                        next_speed = int'(speed[k]) - DECEL_MULT * int'(ramp_step);
                    end
                    // Overshoot past the target stays; only zero and speed_limit bound it.
                    if (next_speed < 0) next_speed = 0;
                    if (next_speed > int'(speed_limit)) next_speed = int'(speed_limit);
                    speed[k] = next_speed[DUTY_W-1:0];
                end
                states[k].duty    = speed[k];
                states[k].forward = forward[k];
            end
            pending_states.push_back(states);
        endfunction

        function void check_wheel_states(logic [M_TDATA_W-1:0] data);
            string      names [WHEELS] = '{"front right", "front left", "rear right",
                                           "rear left"};
            wheel_set_t got;
            wheel_set_t want;
            got = data;
            if (pending_states.size() == 0) begin
                stray_results++;
                if (reported < REPORT_LIMIT) begin
                    reported++;
                    $display("[%0t] unexpected result %h with nothing outstanding",
                             $realtime, data);
                end
                return;
            end
            want = pending_states.pop_front();
            for (int k = 0; k < WHEELS; k++) begin
                if (got[k].duty !== want[k].duty || got[k].forward !== want[k].forward
                        || got[k].flipped !== want[k].flipped) begin
                    mismatches++;
                    if (reported < REPORT_LIMIT) begin
                        reported++;
                        $display({"[%0t] result %0d %s: expected duty %0d forward %b ",
                                  "flipped %b, got duty %0d forward %b flipped %b"},
                                 $realtime, result_index, names[k], want[k].duty,
                                 want[k].forward, want[k].flipped, got[k].duty,
                                 got[k].forward, got[k].flipped);
                    end
                end
            end
            result_index++;
        endfunction
    endclass

    // Clock, reset and all block inputs start at known values.
    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;  // throttle, strafe, rotation, zero pad
    logic                   s_tuser  = 1'b0; // opcode
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;        // duty, forward, flipped per wheel: fr, fl, rr, rl

    wheel_ramp_tracker tracker = new();

    bit hold_off_req = 1'b0;  // raised by the sender, cleared by the receiver when it starts
    bit gap_free     = 1'b0;  // sender offers back to back while set
    int quiet_cycles = 0;

    always #(CLK_HALF) aclk = ~aclk;

    mecanum_mixer_with_ramp_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int demand_clip(int v);
        if (v < DEMAND_MIN) return DEMAND_MIN;
        if (v > DEMAND_MAX) return DEMAND_MAX;
        return v;
    endfunction

    // Offer one command, wait for its transaction, then idle for a random gap.
    task automatic send_command(opcode_t op, int thr, int str, int rot);
        logic signed [DEMAND_W-1:0] t11;
        logic signed [DEMAND_W-1:0] s11;
        logic signed [DEMAND_W-1:0] r11;
        int                         gap;
        t11 = thr[DEMAND_W-1:0];
        s11 = str[DEMAND_W-1:0];
        r11 = rot[DEMAND_W-1:0];
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - 3 * DEMAND_W){1'b0}}, r11, s11, t11};
        do @(posedge aclk); while (!s_tready);
        tracker.note_command(op, t11, s11, r11);
        gap = gap_free ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline empty.
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (tracker.pending_states.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value once pready is seen.
    task automatic write_register(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly held manoeuvres with small jitter so the ramps run to the limit,
    // some stops, and some noise across the full field ranges.
    task automatic random_commands(int count);
        int sent;
        int kind;
        int span;
        int reps;
        int thr;
        int str;
        int rot;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                span = ($urandom_range(0, 4) == 0) ? DEMAND_MAX : 300;
                thr  = int'($urandom_range(0, 2 * span)) - span;
                str  = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 2 * span)) - span;
                rot  = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 2 * span)) - span;
                reps = $urandom_range(1, 25);
                for (int i = 0; i < reps && sent < count; i++) begin
                    send_command(OP_DRIVE,
                                 demand_clip(thr + int'($urandom_range(0, 16)) - 8),
                                 demand_clip(str + int'($urandom_range(0, 16)) - 8),
                                 demand_clip(rot + int'($urandom_range(0, 16)) - 8));
                    sent++;
                end
            end else if (kind < 80) begin
                send_command(OP_STOP, int'($urandom_range(0, 2047)) + DEMAND_MIN,
                             int'($urandom_range(0, 2047)) + DEMAND_MIN,
                             int'($urandom_range(0, 2047)) + DEMAND_MIN);
                sent++;
            end else begin
                send_command(opcode_t'($urandom_range(0, 1)),
                             int'($urandom_range(0, 2047)) + DEMAND_MIN,
                             int'($urandom_range(0, 2047)) + DEMAND_MIN,
                             int'($urandom_range(0, 2047)) + DEMAND_MIN);
                sent++;
            end
        end
    endtask

    // Receiver: random ready bursts and stalls, plus one long hold-off on request.
    initial begin : result_sink
        int ready_span;
        int stall;
        int held;
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge aclk);
                    held++;
                end
            end else begin
                m_tready <= 1'b1;
                ready_span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                         : $urandom_range(1, 8);
                repeat (ready_span) @(posedge aclk);
                stall = pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    // Check every result transaction against the oldest outstanding prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_wheel_states(m_tdata);
        end
    end

    // Abort if neither stream moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int limits [6] = '{255, 0, 128, 255, 37, 200};
        int steps  [6] = '{63, 0, 17, 1, 63, 5};
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed commands under the reset settings (limit 255, step 5).
        send_command(OP_DRIVE, 0, 0, 0);                 // zero target stays forward
        send_command(OP_DRIVE, 100, 0, 0);               // ramp up
        send_command(OP_DRIVE, 100, 0, 0);
        send_command(OP_DRIVE, 7, 0, 0);                 // decelerate below target
        send_command(OP_DRIVE, 9, 0, 0);                 // ramp up toward a small target
        send_command(OP_DRIVE, -100, 0, 0);              // all wheels reverse
        send_command(OP_DRIVE, -100, 0, 0);
        send_command(OP_DRIVE, 0, 50, 0);                // strafe: mixed directions
        send_command(OP_DRIVE, 0, 0, -60);               // rotate the other way
        send_command(OP_DRIVE, DEMAND_MAX, DEMAND_MAX, DEMAND_MAX);
        send_command(OP_DRIVE, DEMAND_MIN, DEMAND_MIN, DEMAND_MIN);
        send_command(OP_DRIVE, DEMAND_MAX, DEMAND_MIN, DEMAND_MAX);
        send_command(OP_DRIVE, DEMAND_MIN, DEMAND_MAX, DEMAND_MIN);
        send_command(OP_DRIVE, DEMAND_MAX, DEMAND_MIN, DEMAND_MIN);
        send_command(OP_DRIVE, 255, 0, 0);               // exactly at the target bound
        send_command(OP_DRIVE, -255, 0, 0);
        send_command(OP_DRIVE, 200, 100, -50);
        send_command(OP_STOP, DEMAND_MAX, DEMAND_MIN, 321); // demands ignored on stop
        send_command(OP_DRIVE, -40, 10, 5);              // directions kept across the stop
        send_command(OP_STOP, 0, 0, 0);
        send_command(OP_DRIVE, 1, -1, 0);

        for (int p = 0; p < 6; p++) begin
            // Pause until every result has come back before touching registers.
            settle_idle();
            write_register(REG_SPEED_LIMIT, limits[p]);
            write_register(REG_RAMP_STEP, steps[p]);
            if (p == 2) begin
                // Hold the receiver off while commands keep coming, so the block
                // fills and stalls its input.
                hold_off_req = 1'b1;
                while (hold_off_req) @(posedge aclk);
                gap_free = 1'b1;
                random_commands(40);
                gap_free = 1'b0;
                random_commands(60);
            end else begin
                // One phase runs without sender gaps.
                gap_free = (p == 4);
                random_commands(100);
                gap_free = 1'b0;
            end
        end

        settle_idle();
        if (tracker.mismatches == 0 && tracker.stray_results == 0
                && tracker.pending_states.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/mmr_pkg.sv
hw/rtl/mecanum_mixer_with_ramp_unit.sv
tb/tb_mecanum_mixer_with_ramp_unit.sv
